>>> hw/rtl/lwbc_pkg.sv
package lwbc_pkg;
   localparam int ENTRIES = 16;
   localparam int SLOT_W = 4;
   localparam int NSTAT = 6;

   typedef enum logic [2:0] {
      MODE_READ = 3'd0, MODE_WRITE = 3'd1, MODE_FLUSH_BLK = 3'd2, MODE_FLUSH_ALL = 3'd3,
      MODE_INVAL = 3'd4, MODE_READ_STAT = 3'd5, MODE_RESET_STATS = 3'd6,
      MODE_FLUSH_CLEAR = 3'd7
   } mode_type;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_FETCH = 2'd2;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   localparam logic [2:0] ST_READS = 3'd0;
   localparam logic [2:0] ST_WRITES = 3'd1;
   localparam logic [2:0] ST_HITS = 3'd2;
   localparam logic [2:0] ST_MISSES = 3'd3;
   localparam logic [2:0] ST_EVICTS = 3'd4;
   localparam logic [2:0] ST_DFLUSH = 3'd5;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOOKUP, CMD_EVICT, CMD_ALLOC, CMD_WALK, CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [SLOT_W-1:0] found_slot;
      logic             found_dirty;
      logic             need_evict;
      logic             victim_dirty;
      logic [SLOT_W-1:0] victim_slot;
      logic [31:0]      victim_tag;
      logic             walk_any;
      logic [SLOT_W-1:0] walk_slot;
      logic [31:0]      walk_tag;
      logic [SLOT_W-1:0] free_slot;
   } sts_type;
endpackage

>>> hw/rtl/lwbc_datapath.sv
module lwbc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lwbc_pkg::cmd_type cmd,
   input  logic [2:0]        mode,
   input  logic [31:0]       block_num,
   input  logic [4:0]        capacity,
   output lwbc_pkg::sts_type sts
);
   import lwbc_pkg::*;

   logic [ENTRIES-1:0] valid_ff, valid_in, dirty_ff, dirty_in;
   logic [31:0]        tag_ff [ENTRIES];
   logic [SLOT_W-1:0]  rank_ff [ENTRIES];
   logic [SLOT_W-1:0]  rank_in [ENTRIES];
   logic [4:0]         occ_ff, occ_in, cap_eff;
   logic [SLOT_W-1:0]  tgt, tgt_rank;
   logic               do_drop, do_touch;

   always_comb begin
      sts = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == block_num) begin
            sts.found = 1'b1;
            sts.found_slot = SLOT_W'(i);
         end
         if (!valid_ff[i]) sts.free_slot = SLOT_W'(i);
         if (valid_ff[i] && dirty_ff[i]) begin
            sts.walk_any = 1'b1;
            sts.walk_slot = SLOT_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++)
         if (valid_ff[i] && rank_ff[i] == SLOT_W'(occ_ff - 5'd1)) begin
            sts.victim_slot = SLOT_W'(i);
         end
      sts.victim_dirty = dirty_ff[sts.victim_slot];
      sts.victim_tag = tag_ff[sts.victim_slot];
      sts.walk_tag = tag_ff[sts.walk_slot];
      sts.found_dirty = dirty_ff[sts.found_slot];
      cap_eff = (capacity == 5'd0) ? 5'd1 :
                (capacity > 5'(ENTRIES)) ? 5'(ENTRIES) : capacity;
      sts.need_evict = (occ_ff != 5'd0) && (occ_ff >= cap_eff);
   end

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      occ_in = occ_ff;
      rank_in = rank_ff;
      do_drop = 1'b0;
      do_touch = 1'b0;
      tgt = sts.found_slot;
      case (cmd.op)
         CMD_LOOKUP: begin
            case (mode)
               MODE_READ: do_touch = sts.found;
               MODE_WRITE: begin
                  do_touch = sts.found;
                  if (sts.found) dirty_in[tgt] = 1'b1;
               end
               MODE_FLUSH_BLK: if (sts.found) dirty_in[tgt] = 1'b0;
               MODE_INVAL: do_drop = sts.found;
               default: ;
            endcase
         end
         CMD_EVICT: begin
            tgt = sts.victim_slot;
            do_drop = 1'b1;
         end
         CMD_ALLOC: begin
            tgt = sts.free_slot;
            for (int i = 0; i < ENTRIES; i++)
               if (valid_ff[i]) rank_in[i] = rank_ff[i] + SLOT_W'(1);
            rank_in[tgt] = '0;
            valid_in[tgt] = 1'b1;
            dirty_in[tgt] = (mode == MODE_WRITE);
            occ_in = occ_ff + 5'd1;
         end
         CMD_WALK: dirty_in[sts.walk_slot] = 1'b0;
         CMD_CLEAR: begin
            valid_in = '0;
            dirty_in = '0;
            occ_in = '0;
         end
         default: ;
      endcase
      tgt_rank = rank_ff[tgt];
      if (do_touch) begin
         for (int i = 0; i < ENTRIES; i++)
            if (valid_ff[i] && rank_ff[i] < tgt_rank) rank_in[i] = rank_ff[i] + SLOT_W'(1);
         rank_in[tgt] = '0;
      end
      if (do_drop) begin
         valid_in[tgt] = 1'b0;
         dirty_in[tgt] = 1'b0;
         for (int i = 0; i < ENTRIES; i++)
            if (valid_ff[i] && rank_ff[i] > tgt_rank) rank_in[i] = rank_ff[i] - SLOT_W'(1);
         if (occ_ff != 5'd0) occ_in = occ_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         occ_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         occ_ff <= occ_in;
      end
      rank_ff <= rank_in;
      if (cmd.op == CMD_ALLOC) tag_ff[sts.free_slot] <= block_num;
   end
endmodule

>>> hw/rtl/lwbc_control.sv
module lwbc_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_mode,
   input  logic [31:0]       req_block_num,
   input  logic [2:0]        req_stat_select,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_action,
   output logic [31:0]       rsp_disk_block,
   output logic [3:0]        rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_status,
   output logic [31:0]       rsp_stat_value,
   output logic              rsp_last,
   input  logic              enable,
   output lwbc_pkg::cmd_type cmd,
   output logic [2:0]        mode,
   output logic [31:0]       block_num,
   input  lwbc_pkg::sts_type sts
);
   import lwbc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_EVICT, S_WALK} state_type;

   state_type   state_ff;
   logic [2:0]  mode_ff, sel_ff;
   logic [31:0] blk_ff;
   logic [31:0] stat_ff [NSTAT];
   logic        ov_ff;
   logic [1:0]  act_ff;
   logic [31:0] disk_ff, sval_ff;
   logic [3:0]  slot_ff;
   logic        hit_ff, status_ff, last_ff;
   logic        out_free;

   assign out_free = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign mode = mode_ff;
   assign block_num = blk_ff;
   assign rsp_valid = ov_ff;
   assign rsp_action = act_ff;
   assign rsp_disk_block = disk_ff;
   assign rsp_slot = slot_ff;
   assign rsp_hit = hit_ff;
   assign rsp_status = status_ff;
   assign rsp_stat_value = sval_ff;
   assign rsp_last = last_ff;

   always_comb begin
      cmd.op = CMD_NONE;
      if (out_free) begin
         case (state_ff)
            S_EXEC:  if (enable) cmd.op = CMD_LOOKUP;
            S_EVICT: cmd.op = sts.need_evict ? CMD_EVICT : CMD_ALLOC;
            S_WALK:  cmd.op = sts.walk_any ? CMD_WALK :
                              (mode_ff == MODE_FLUSH_CLEAR) ? CMD_CLEAR : CMD_NONE;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         for (int i = 0; i < NSTAT; i++) stat_ff[i] <= '0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid) begin
               mode_ff <= req_mode;
               blk_ff <= req_block_num;
               sel_ff <= req_stat_select;
               state_ff <= S_EXEC;
            end
            S_EXEC: if (out_free) begin
               ov_ff <= 1'b1;
               act_ff <= ACT_NONE;
               disk_ff <= blk_ff;
               slot_ff <= '0;
               hit_ff <= 1'b0;
               status_ff <= 1'b0;
               sval_ff <= '0;
               last_ff <= 1'b1;
               state_ff <= S_IDLE;
               case (mode_ff)
                  MODE_READ, MODE_WRITE: begin
                     if (!enable) act_ff <= (mode_ff == MODE_READ) ? ACT_FETCH : ACT_WRITE;
                     else begin
                        stat_ff[(mode_ff == MODE_READ) ? ST_READS : ST_WRITES] <=
                           stat_ff[(mode_ff == MODE_READ) ? ST_READS : ST_WRITES] + 1;
                        if (sts.found) begin
                           stat_ff[ST_HITS] <= stat_ff[ST_HITS] + 1;
                           slot_ff <= sts.found_slot;
                           hit_ff <= 1'b1;
                        end else begin
                           stat_ff[ST_MISSES] <= stat_ff[ST_MISSES] + 1;
                           ov_ff <= 1'b0;
                           state_ff <= S_EVICT;
                        end
                     end
                  end
                  MODE_FLUSH_BLK: begin
                     if (!enable) status_ff <= 1'b1;
                     else if (sts.found) begin
                        slot_ff <= sts.found_slot;
                        hit_ff <= 1'b1;
                        if (sts.found_dirty) begin
                           act_ff <= ACT_WRITE;
                           stat_ff[ST_DFLUSH] <= stat_ff[ST_DFLUSH] + 1;
                        end
                     end
                  end
                  MODE_FLUSH_ALL, MODE_FLUSH_CLEAR: begin
                     if (!enable) status_ff <= (mode_ff == MODE_FLUSH_ALL);
                     else begin
                        ov_ff <= 1'b0;
                        state_ff <= S_WALK;
                     end
                  end
                  MODE_INVAL: if (enable && sts.found) begin
                     slot_ff <= sts.found_slot;
                     hit_ff <= 1'b1;
                  end
                  MODE_READ_STAT:
                     sval_ff <= (sel_ff < 3'(NSTAT)) ? stat_ff[sel_ff] : '0;
                  MODE_RESET_STATS:
                     for (int i = 0; i < NSTAT; i++) stat_ff[i] <= '0;
                  default: ;
               endcase
            end
            S_EVICT: if (out_free) begin
               hit_ff <= 1'b0;
               status_ff <= 1'b0;
               sval_ff <= '0;
               if (sts.need_evict) begin
                  stat_ff[ST_EVICTS] <= stat_ff[ST_EVICTS] + 1;
                  if (sts.victim_dirty) begin
                     stat_ff[ST_DFLUSH] <= stat_ff[ST_DFLUSH] + 1;
                     ov_ff <= 1'b1;
                     act_ff <= ACT_WRITE;
                     disk_ff <= sts.victim_tag;
                     slot_ff <= sts.victim_slot;
                     last_ff <= 1'b0;
                  end
               end else begin
                  ov_ff <= 1'b1;
                  act_ff <= (mode_ff == MODE_READ) ? ACT_FETCH : ACT_NONE;
                  disk_ff <= blk_ff;
                  slot_ff <= sts.free_slot;
                  last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_WALK: if (out_free) begin
               ov_ff <= 1'b1;
               hit_ff <= 1'b0;
               status_ff <= 1'b0;
               sval_ff <= '0;
               if (sts.walk_any) begin
                  stat_ff[ST_DFLUSH] <= stat_ff[ST_DFLUSH] + 1;
                  act_ff <= ACT_WRITE;
                  disk_ff <= sts.walk_tag;
                  slot_ff <= sts.walk_slot;
                  last_ff <= 1'b0;
               end else begin
                  act_ff <= ACT_NONE;
                  disk_ff <= blk_ff;
                  slot_ff <= '0;
                  last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> hw/rtl/lru_writeback_block_cache.sv
// fully associative write-back block cache controller, 16 entries, lru replacement
// request channel req_*: mode, block_num, stat_select, taken when valid and not stall
// result channel rsp_*: one or more words per request, rsp_last marks the final word
// a request is taken and its words follow from a lookup in the exec state;
// a miss first evicts lru entries (a word per dirty victim) while at capacity, then allocates;
// flush-all writes one word per dirty entry, then a final word (slots walked low to high)
// req_stall stays high until the last word of a request is registered
// the result register holds its word while rsp_stall is high and the engine waits
// csr port: index 0 enable, index 1 capacity (clamped to 1..16); write only when idle
// reset clears valid/dirty bits, occupancy, counters, enable to 0 and capacity to 16
module lru_writeback_block_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_block_num,
   input  logic [2:0]  req_stat_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_disk_block,
   output logic [3:0]  rsp_slot,
   output logic        rsp_hit,
   output logic        rsp_status,
   output logic [31:0] rsp_stat_value,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   import lwbc_pkg::*;

   logic        enable_ff;
   logic [4:0]  capacity_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [2:0]  mode;
   logic [31:0] block_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         capacity_ff <= 5'(ENTRIES);
      end else if (csr_write) begin
         if (csr_index == CSR_ENABLE) enable_ff <= csr_data[0];
         else capacity_ff <= csr_data;
      end
   end

   lwbc_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_block_num,
      .req_stat_select, .rsp_valid, .rsp_stall, .rsp_action, .rsp_disk_block,
      .rsp_slot, .rsp_hit, .rsp_status, .rsp_stat_value, .rsp_last,
      .enable(enable_ff), .cmd, .mode, .block_num, .sts
   );

   lwbc_datapath u_dp (
      .clock, .reset, .cmd, .mode, .block_num, .capacity(capacity_ff), .sts
   );
endmodule
